// ===== rtl/dedf_pkg.sv =====
// Shared constants, codes and control structs of the debounced edge event queue.
package dedf_pkg;

  localparam int unsigned CHANNELS = 8;
  localparam int unsigned DEPTH    = 128;

  localparam int unsigned CH_W     = 3;
  localparam int unsigned TIMER_W  = 16;
  localparam int unsigned PTR_W    = $clog2(DEPTH);
  localparam int unsigned ENTRY_W  = CH_W + 1;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned DROP_W   = 4;
  localparam int unsigned MASK_W   = 8;

  localparam logic [TIMER_W-1:0] DEBOUNCE_RESET = TIMER_W'(20);
  localparam logic [CH_W-1:0]    LAST_CH        = CH_W'(CHANNELS - 1);

  typedef enum logic [1:0] {
    OP_EDGE = 2'd0,
    OP_TICK = 2'd1,
    OP_POP  = 2'd2,
    OP_NOP  = 2'd3
  } opcode_e;

  // One step of the shared timer unit
  typedef struct packed {
    logic            en;
    logic            load;
    logic            tick;
    logic [CH_W-1:0] ch;
  } tmr_ctrl_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  typedef struct packed {
    logic             full;
    logic             nonempty;
    logic [PTR_W-1:0] count;
  } fifo_stat_t;

endpackage

// ===== rtl/dedf_in_if.sv =====
// Input channel: one opcode item with edge mask and pin levels.
interface dedf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] edge_mask;
  logic [7:0] pin_levels;

  modport source (output valid, opcode, edge_mask, pin_levels, input ready);
  modport sink   (input valid, opcode, edge_mask, pin_levels, output ready);
endinterface

// ===== rtl/dedf_out_if.sv =====
// Output channel: one result item per accepted input item.
interface dedf_out_if;
  logic       valid;
  logic       ready;
  logic       read_valid;
  logic [2:0] event_channel;
  logic       event_level;
  logic       fifo_nonempty;
  logic [6:0] fifo_count;
  logic [3:0] dropped_events;

  modport source (output valid, read_valid, event_channel, event_level, fifo_nonempty,
                  fifo_count, dropped_events, input ready);
  modport sink   (input valid, read_valid, event_channel, event_level, fifo_nonempty,
                  fifo_count, dropped_events, output ready);
endinterface

// ===== rtl/debounced_edge_event_fifo.sv =====
// Top level: sequencer over the timer unit and the event ring, with an output register.
// An edge or tick item walks the channels in ascending order, one channel a cycle
// through the shared timer unit, between acceptance and the posting of the result;
// a tick pushes at most one event a cycle into the ring. A pop item goes through a
// read state, which takes the registered read of the event memory, before the
// result state, and a no-operation item goes straight to the result state. The
// result is held in an output register, so the next item is taken while it waits.
// The ring keeps up to 127 events; pushes beyond that are dropped and counted.
module debounced_edge_event_fifo (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dedf_pkg::TIMER_W-1:0]     cfg_wdata_i,
  dedf_in_if.sink                          in_i,
  dedf_out_if.source                       out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_POP,
    S_DONE
  } state_e;

  state_e                             state_q;
  dedf_pkg::opcode_e                  op_q;
  logic [dedf_pkg::MASK_W-1:0]        mask_q, lvl_q;
  logic [dedf_pkg::CH_W-1:0]          ch_q;
  logic [dedf_pkg::DROP_W-1:0]        drop_q;
  logic                               popv_q;
  logic [dedf_pkg::ENTRY_W-1:0]       ev_q;
  logic [dedf_pkg::TIMER_W-1:0]       debounce_q;
  logic                               out_valid_q;
  logic                               out_rv_q, out_lvl_q, out_ne_q;
  logic [dedf_pkg::CH_W-1:0]          out_ch_q;
  logic [dedf_pkg::COUNT_W-1:0]       out_cnt_q;
  logic [dedf_pkg::DROP_W-1:0]        out_drop_q;

  dedf_pkg::tmr_ctrl_t                tmr_ctrl;
  dedf_pkg::fifo_ctrl_t               fifo_ctrl;
  dedf_pkg::fifo_stat_t               fifo_stat;
  logic [dedf_pkg::ENTRY_W-1:0]       fifo_rdata;
  logic                               fire;
  logic                               in_acc, out_free;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // Timer unit step for the current channel
  assign tmr_ctrl.en   = (state_q == S_WALK);
  assign tmr_ctrl.ch   = ch_q;
  assign tmr_ctrl.load = (op_q == dedf_pkg::OP_EDGE) && mask_q[ch_q];
  assign tmr_ctrl.tick = (op_q == dedf_pkg::OP_TICK);

  // Push the expiring channel, pop when a queued event was taken
  assign fifo_ctrl.push = fire;
  assign fifo_ctrl.pop  = (state_q == S_POP) && popv_q;

  dedf_timer_unit u_timer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (tmr_ctrl),
    .load_val_i (debounce_q),
    .fire_o     (fire)
  );

  dedf_event_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (fifo_ctrl),
    .wdata_i ({ch_q, lvl_q[ch_q]}),
    .rdata_o (fifo_rdata),
    .stat_o  (fifo_stat)
  );

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= dedf_pkg::DEBOUNCE_RESET;
    end else if (cfg_we_i) begin
      debounce_q <= cfg_wdata_i;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= dedf_pkg::OP_NOP;
      mask_q      <= '0;
      lvl_q       <= '0;
      ch_q        <= '0;
      drop_q      <= '0;
      popv_q      <= 1'b0;
      ev_q        <= '0;
      out_valid_q <= 1'b0;
      out_rv_q    <= 1'b0;
      out_ch_q    <= '0;
      out_lvl_q   <= 1'b0;
      out_ne_q    <= 1'b0;
      out_cnt_q   <= '0;
      out_drop_q  <= '0;
    end else begin
      // Post a finished result, drop the held one once taken
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_q   <= dedf_pkg::opcode_e'(in_i.opcode);
            mask_q <= in_i.edge_mask;
            lvl_q  <= in_i.pin_levels;
            ch_q   <= '0;
            drop_q <= '0;
            popv_q <= fifo_stat.nonempty;
            ev_q   <= '0;
            unique case (dedf_pkg::opcode_e'(in_i.opcode))
              dedf_pkg::OP_EDGE: state_q <= S_WALK;
              dedf_pkg::OP_TICK: state_q <= S_WALK;
              dedf_pkg::OP_POP:  state_q <= S_POP;
              dedf_pkg::OP_NOP:  state_q <= S_DONE;
            endcase
          end
        end
        S_WALK: begin
          if (fire && fifo_stat.full) begin
            drop_q <= drop_q + dedf_pkg::DROP_W'(1);
          end
          if (ch_q == dedf_pkg::LAST_CH) begin
            state_q <= S_DONE;
          end else begin
            ch_q <= ch_q + dedf_pkg::CH_W'(1);
          end
        end
        S_POP: begin
          if (popv_q) begin
            ev_q <= fifo_rdata;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_rv_q    <= popv_q && (op_q == dedf_pkg::OP_POP);
            out_ch_q    <= ev_q[dedf_pkg::ENTRY_W-1:1];
            out_lvl_q   <= ev_q[0];
            out_ne_q    <= fifo_stat.nonempty;
            out_cnt_q   <= dedf_pkg::COUNT_W'(fifo_stat.count);
            out_drop_q  <= drop_q;
            state_q     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.read_valid     = out_rv_q;
  assign out_o.event_channel  = out_ch_q;
  assign out_o.event_level    = out_lvl_q;
  assign out_o.fifo_nonempty  = out_ne_q;
  assign out_o.fifo_count     = out_cnt_q;
  assign out_o.dropped_events = out_drop_q;

endmodule

// ===== rtl/dedf_timer_unit.sv =====
// Per-channel debounce timers with one shared decrement and expiry compare.
module dedf_timer_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dedf_pkg::tmr_ctrl_t                ctrl_i,
  input  logic [dedf_pkg::TIMER_W-1:0]       load_val_i,
  output logic                               fire_o
);

  logic [dedf_pkg::TIMER_W-1:0]  timer_q [dedf_pkg::CHANNELS];
  logic [dedf_pkg::CHANNELS-1:0] armed_q;
  logic [dedf_pkg::TIMER_W-1:0]  cur;
  logic [dedf_pkg::TIMER_W-1:0]  dec;
  logic                          expire;

  // Shared unit: select one channel, compare and decrement
  assign cur    = timer_q[ctrl_i.ch];
  assign expire = (cur <= dedf_pkg::TIMER_W'(1));
  assign dec    = cur - dedf_pkg::TIMER_W'(1);
  assign fire_o = ctrl_i.en && ctrl_i.tick && armed_q[ctrl_i.ch] && expire;

  // Restart on edge, count down on tick, disarm on expiry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
      for (int i = 0; i < dedf_pkg::CHANNELS; i++) begin
        timer_q[i] <= '0;
      end
    end else if (ctrl_i.en) begin
      if (ctrl_i.load) begin
        timer_q[ctrl_i.ch] <= load_val_i;
        armed_q[ctrl_i.ch] <= 1'b1;
      end else if (ctrl_i.tick && armed_q[ctrl_i.ch]) begin
        if (expire) begin
          timer_q[ctrl_i.ch] <= '0;
          armed_q[ctrl_i.ch] <= 1'b0;
        end else begin
          timer_q[ctrl_i.ch] <= dec;
        end
      end
    end
  end

endmodule

// ===== rtl/dedf_event_fifo.sv =====
// Event ring of DEPTH slots holding up to DEPTH-1 entries, registered read.
module dedf_event_fifo (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dedf_pkg::fifo_ctrl_t             ctrl_i,
  input  logic [dedf_pkg::ENTRY_W-1:0]     wdata_i,
  output logic [dedf_pkg::ENTRY_W-1:0]     rdata_o,
  output dedf_pkg::fifo_stat_t             stat_o
);

  logic [dedf_pkg::ENTRY_W-1:0] mem_q [dedf_pkg::DEPTH];
  logic [dedf_pkg::ENTRY_W-1:0] rdata_q;
  logic [dedf_pkg::PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [dedf_pkg::PTR_W-1:0]   wr_nxt, rd_nxt;
  logic                         push_ok, pop_ok;

  // Wrap pointers at the ring length
  assign wr_nxt = (wr_ptr_q == dedf_pkg::PTR_W'(dedf_pkg::DEPTH - 1)) ? '0
                : wr_ptr_q + dedf_pkg::PTR_W'(1);
  assign rd_nxt = (rd_ptr_q == dedf_pkg::PTR_W'(dedf_pkg::DEPTH - 1)) ? '0
                : rd_ptr_q + dedf_pkg::PTR_W'(1);

  assign stat_o.full     = (wr_nxt == rd_ptr_q);
  assign stat_o.nonempty = (wr_ptr_q != rd_ptr_q);
  assign stat_o.count    = (wr_ptr_q >= rd_ptr_q) ? wr_ptr_q - rd_ptr_q
                         : dedf_pkg::PTR_W'(dedf_pkg::DEPTH - 32'(rd_ptr_q) + 32'(wr_ptr_q));

  assign push_ok = ctrl_i.push && !stat_o.full;
  assign pop_ok  = ctrl_i.pop && stat_o.nonempty;
  assign rdata_o = rdata_q;

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= wr_nxt;
      end
      if (pop_ok) begin
        rd_ptr_q <= rd_nxt;
      end
    end
  end

  // Storage and registered read of the oldest slot
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
    rdata_q <= mem_q[rd_ptr_q];
  end

endmodule

// ===== rtl/dedf_checker.sv =====
// Port-level checks of the debounced edge event queue and their binding.
module dedf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       read_valid_i,
  input logic       fifo_nonempty_i,
  input logic [6:0] fifo_count_i,
  input logic [3:0] dropped_events_i
);

  // One item at a time: ready drops after an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while an item is in work");

  // A pop never discards events
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && read_valid_i |-> dropped_events_i == 4'd0)
    else $error("pop result reports dropped events");

  // Status flag agrees with the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> fifo_nonempty_i == (fifo_count_i != 7'd0))
    else $error("nonempty flag disagrees with count");

  // At most one drop per channel in a tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> dropped_events_i <= 4'd8)
    else $error("more drops than channels");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(fifo_count_i))
    else $error("stalled result changed");

endmodule

bind debounced_edge_event_fifo dedf_checker u_dedf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .read_valid_i     (out_o.read_valid),
  .fifo_nonempty_i  (out_o.fifo_nonempty),
  .fifo_count_i     (out_o.fifo_count),
  .dropped_events_i (out_o.dropped_events)
);
